// ===== sv/nst_pkg.sv =====
// Shared types, constants and pitch tables for the note slice transposer.
package nst_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_MOD
  } state_t;

  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_PATTERN  = 2'd0;
  localparam reg_index_t REG_LENGTH   = 2'd1;
  localparam reg_index_t REG_CAPACITY = 2'd2;

  localparam logic [3:0] MAX_PATTERN   = 4'd8;
  localparam logic [3:0] PAUSE_CODE    = 4'd8;
  localparam logic [3:0] LAST_LETTER   = 4'd7;
  localparam logic [1:0] ACC_NATURAL   = 2'd0;
  localparam logic [1:0] ACC_FLAT      = 2'd1;
  localparam logic [1:0] ACC_SHARP     = 2'd2;
  localparam logic [7:0] IDX_INVALID   = 8'd255;
  localparam logic [6:0] WHOLE_SLICES  = 7'd64;
  localparam logic [2:0] LEN_SHORTEST  = 3'd6;
  // 171 / 2048 approximates 1/12 closely enough for any 8-bit index
  localparam logic [7:0] RECIP_12      = 8'd171;
  localparam int         RECIP_SHIFT   = 11;

  typedef struct packed {
    logic accept;
    logic emit;
    logic mod_step;
  } cmd_t;

  typedef struct packed {
    logic len_written;
    logic can_emit;
    logic last;
    logic out_free;
    logic mod_last;
  } status_t;

  function automatic logic [3:0] tone_of_letter(input logic [2:0] letter);
    logic [3:0] tone;
    unique case (letter)
      3'd0:    tone = 4'd9;
      3'd1:    tone = 4'd10;
      3'd2:    tone = 4'd0;
      3'd3:    tone = 4'd2;
      3'd4:    tone = 4'd4;
      3'd5:    tone = 4'd5;
      3'd6:    tone = 4'd7;
      default: tone = 4'd11;
    endcase
    return tone;
  endfunction

  function automatic logic [3:0] letter_of_tone(input logic [3:0] tone);
    logic [3:0] letter;
    unique case (tone)
      4'd0, 4'd1:  letter = 4'd2;
      4'd2, 4'd3:  letter = 4'd3;
      4'd4:        letter = 4'd4;
      4'd5, 4'd6:  letter = 4'd5;
      4'd7, 4'd8:  letter = 4'd6;
      4'd9, 4'd10: letter = 4'd0;
      default:     letter = 4'd7;
    endcase
    return letter;
  endfunction

  function automatic logic sharp_of_tone(input logic [3:0] tone);
    return (tone == 4'd1) || (tone == 4'd3) || (tone == 4'd6) ||
           (tone == 4'd8) || (tone == 4'd10);
  endfunction

endpackage

// ===== sv/nst_ctrl.sv =====
// Sequencer: note intake, slice emission and pattern position recompute.
module nst_ctrl
  import nst_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != ST_IDLE) || st.len_written;
    unique case (state)
      ST_IDLE: begin
        if (st.len_written) begin
          state_next = ST_MOD;
        end else if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!st.can_emit) begin
          state_next = ST_IDLE;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last) state_next = ST_IDLE;
        end
      end
      ST_MOD: begin
        // a fresh length write restarts the remainder pass
        if (!st.len_written) begin
          cmd.mod_step = 1'b1;
          if (st.mod_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/nst_dp.sv =====
// Datapath: config registers, note latch, slice counter, transposer, output register.
module nst_dp
  import nst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  reg_index_t  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        first_note,
  input  logic [3:0]  pitch_letter,
  input  logic [3:0]  octave_number,
  input  logic [1:0]  accidental,
  input  logic [2:0]  length_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] slice_index,
  output logic [3:0]  out_letter,
  output logic [1:0]  out_accidental,
  output logic [4:0]  out_octave,
  output logic        fill_continuous,
  output logic        last_slice,
  input  cmd_t        cmd,
  output status_t     st
);

  logic [63:0] shift_pattern;
  logic [3:0]  shift_length;
  logic [15:0] dest_capacity;
  logic [15:0] slice_count;
  logic [2:0]  pat_pos;
  logic [6:0]  remaining;
  logic [15:0] mod_shift;
  logic [3:0]  mod_cnt;

  logic [3:0]  note_letter;
  logic [3:0]  note_octave;
  logic [1:0]  note_acc;
  logic        note_pause;
  logic        note_tuned;
  logic [7:0]  note_base;

  logic [3:0]  plen;
  logic        len_wr;
  logic [7:0]  oct_m1;
  logic [7:0]  base_raw;
  logic [7:0]  base_idx;
  logic        in_tuned;
  logic [6:0]  in_slices;
  logic [7:0]  shift_amt;
  logic [7:0]  idx;
  logic [15:0] prod;
  logic [4:0]  quot;
  logic [7:0]  rem_full;
  logic [3:0]  tone;
  logic [3:0]  pos_inc;
  logic [3:0]  mod_r;

  assign cfg_ready = 1'b1;
  assign len_wr    = cfg_valid && (cfg_index == REG_LENGTH);

  always_comb begin
    if (shift_length == 4'd0) begin
      plen = 4'd1;
    end else if (shift_length > MAX_PATTERN) begin
      plen = MAX_PATTERN;
    end else begin
      plen = shift_length;
    end
  end

  // halftone index of the incoming note, 8-bit wrap
  assign oct_m1   = {4'd0, octave_number} - 8'd1;
  assign base_raw = {4'd0, tone_of_letter(pitch_letter[2:0])} +
                    {oct_m1[4:0], 3'b000} + {oct_m1[5:0], 2'b00};
  always_comb begin
    case (accidental)
      ACC_FLAT:  base_idx = base_raw - 8'd1;
      ACC_SHARP: base_idx = base_raw + 8'd1;
      default:   base_idx = base_raw;
    endcase
  end
  assign in_tuned  = (pitch_letter <= LAST_LETTER) && (octave_number >= 4'd1) &&
                     (octave_number <= 4'd7) && (base_idx != IDX_INVALID);
  assign in_slices = (length_code <= LEN_SHORTEST) ? (WHOLE_SLICES >> length_code) : 7'd0;

  // per-slice transpose: idx / 12 by reciprocal multiply, remainder by subtract
  assign shift_amt = shift_pattern[{pat_pos, 3'b000} +: 8];
  assign idx       = note_base + shift_amt;
  assign prod      = {8'd0, idx} * {8'd0, RECIP_12};
  assign quot      = prod[RECIP_SHIFT +: 5];
  assign rem_full  = idx - ({1'b0, quot, 2'b00} + {quot, 3'b000});
  assign tone      = rem_full[3:0];

  assign pos_inc = {1'b0, pat_pos} + 4'd1;
  assign mod_r   = {pat_pos, mod_shift[15]};

  assign st.len_written = len_wr;
  assign st.can_emit    = (remaining != 7'd0) && (slice_count < dest_capacity);
  assign st.last        = (remaining == 7'd1) || ((slice_count + 16'd1) == dest_capacity);
  assign st.out_free    = !out_valid || !out_stall;
  assign st.mod_last    = (mod_cnt == 4'hF);

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_pattern <= '0;
      shift_length  <= 4'd1;
      dest_capacity <= 16'hFFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN:  shift_pattern <= cfg_data;
        REG_LENGTH:   shift_length  <= cfg_data[3:0];
        REG_CAPACITY: dest_capacity <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_count <= '0;
      pat_pos     <= '0;
      remaining   <= '0;
      mod_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (len_wr) begin
        pat_pos   <= '0;
        mod_cnt   <= '0;
        mod_shift <= slice_count;
      end else if (cmd.mod_step) begin
        // restoring remainder, one count bit a cycle
        pat_pos   <= (mod_r >= plen) ? 3'(mod_r - plen) : mod_r[2:0];
        mod_shift <= {mod_shift[14:0], 1'b0};
        mod_cnt   <= mod_cnt + 4'd1;
      end else if (cmd.accept) begin
        remaining <= in_slices;
        if (first_note) begin
          slice_count <= '0;
          pat_pos     <= '0;
        end
      end else if (cmd.emit) begin
        remaining   <= remaining - 7'd1;
        slice_count <= slice_count + 16'd1;
        pat_pos     <= (pos_inc == plen) ? 3'd0 : pos_inc[2:0];
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      note_letter <= pitch_letter;
      note_octave <= octave_number;
      note_acc    <= accidental;
      note_pause  <= (pitch_letter == PAUSE_CODE);
      note_tuned  <= in_tuned;
      note_base   <= base_idx;
    end
    if (cmd.emit) begin
      slice_index     <= slice_count;
      fill_continuous <= !note_pause;
      last_slice      <= st.last;
      if (note_tuned) begin
        out_letter     <= letter_of_tone(tone);
        out_accidental <= sharp_of_tone(tone) ? ACC_SHARP : ACC_NATURAL;
        out_octave     <= quot + 5'd1;
      end else begin
        out_letter     <= note_letter;
        out_accidental <= note_acc;
        out_octave     <= {1'b0, note_octave};
      end
    end
  end

  a_emit_below_cap: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> slice_count < dest_capacity)
    else $error("slice emitted at or past capacity");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pat_pos} < plen)
    else $error("pattern position outside pattern length");

  a_emit_loads_out: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted slice not presented");

  a_last_ends_note: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && st.last |=> !st.can_emit)
    else $error("slices remain after last slice");

endmodule

// ===== sv/note_slice_transposer.sv =====
// Top level of the note slice transposer: sequencer plus datapath.
//
// Usage: one note enters on the input channel (in_valid / in_stall) and is cut
// into 64th-note slices that leave on the output channel (out_valid /
// out_stall), one slice per transfer. A whole note gives 64 slices, a 64th
// gives one, a 128th or unknown length gives none. Sounding slices are
// transposed by the shift pattern entry chosen by the running slice count.
// After the note transfer the sequencer enters its emit state; each slice is
// registered in the output register. Slices then leave one per cycle while
// the receiver does not stall; a note that yields no slice sends the
// sequencer back to idle. The remaining-slice counter and capacity end a note.
// The input stalls while a note is being sliced; the last slice may still sit
// in the output register while the next note is taken.
// Writing shift_length starts a bit-serial remainder pass that realigns the
// pattern position to the slice count; the input stalls meanwhile.
// Reset clears the slice count and loads pattern 0, length 1, capacity 65535.
// When the receiver stalls, the output register holds its slice and slicing
// pauses until it is taken.
module note_slice_transposer
  import nst_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_note,
  input  logic [3:0]  pitch_letter,
  input  logic [3:0]  octave_number,
  input  logic [1:0]  accidental,
  input  logic [2:0]  length_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] slice_index,
  output logic [3:0]  out_letter,
  output logic [1:0]  out_accidental,
  output logic [4:0]  out_octave,
  output logic        fill_continuous,
  output logic        last_slice
);

  cmd_t    cmd;
  status_t st;

  nst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  nst_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .first_note      (first_note),
    .pitch_letter    (pitch_letter),
    .octave_number   (octave_number),
    .accidental      (accidental),
    .length_code     (length_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .slice_index     (slice_index),
    .out_letter      (out_letter),
    .out_accidental  (out_accidental),
    .out_octave      (out_octave),
    .fill_continuous (fill_continuous),
    .last_slice      (last_slice),
    .cmd             (cmd),
    .st              (st)
  );

endmodule
